FILE: design/smf_pkg.sv
// Package for the searchable message FIFO: sizes, command and status codes.
// No dependencies.
`timescale 1ns / 1ps
package smf_pkg;
    localparam int Capacity   = 64;
    localparam int SlotBits   = $clog2(Capacity);
    localparam int CountBits  = $clog2(Capacity + 1);
    localparam int HandleBits = 16;
    localparam int CodeBits   = 32;
    localparam int PosBits    = 10;

    typedef logic [SlotBits-1:0]   slot_t;
    typedef logic [CountBits-1:0]  count_t;
    typedef logic [HandleBits-1:0] handle_t;
    typedef logic [CodeBits-1:0]   code_t;
    typedef logic [PosBits-1:0]    pos_t;

    typedef enum logic [2:0] {
        CMD_APPEND    = 3'd0,
        CMD_REMOVE    = 3'd1,
        CMD_FIND_AT   = 3'd2,
        CMD_FIND_CODE = 3'd3,
        CMD_POP       = 3'd4,
        CMD_IS_HEAD   = 3'd5
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_MISSING = 2'd1,
        ST_FULL    = 2'd2,
        ST_NULL    = 2'd3
    } status_t;

    typedef struct packed {
        logic [2:0] cmd;
        handle_t    handle;
        code_t      code;
        pos_t       position;
    } req_t;

    typedef struct packed {
        logic [1:0] status;
        handle_t    handle_out;
        code_t      code_out;
        count_t     count_out;
    } rsp_t;

    // One slot read/write bundle between the controller and the slot store
    typedef struct packed {
        logic    rd_en;
        slot_t   rd_addr;
        logic    ent_we;
        slot_t   ent_addr;
        handle_t ent_handle;
        code_t   ent_code;
        logic    lnk_we;
        slot_t   lnk_addr;
        slot_t   lnk_data;
    } mem_req_t;
endpackage

FILE: design/smf_if.sv
// Valid/ready channel interfaces for the searchable message FIFO.
// Depends on smf_pkg.
`timescale 1ns / 1ps
interface smf_req_if;
    import smf_pkg::*;
    logic valid;
    logic ready;
    logic [2:0] cmd;
    handle_t handle;
    code_t code;
    pos_t position;
    modport source (output valid, cmd, handle, code, position, input ready);
    modport sink (input valid, cmd, handle, code, position, output ready);
endinterface

interface smf_rsp_if;
    import smf_pkg::*;
    logic valid;
    logic ready;
    logic [1:0] status;
    handle_t handle_out;
    code_t code_out;
    count_t count_out;
    modport source (output valid, status, handle_out, code_out, count_out, input ready);
    modport sink (input valid, status, handle_out, code_out, count_out, output ready);
endinterface

FILE: design/smf_store.sv
// Slot store: entry memory (handle, code) and link memory, registered reads.
// Depends on smf_pkg. Link memory is chained as a free list by a sweep after reset.
`timescale 1ns / 1ps
module smf_store (
    input  logic              clk,
    input  logic              rst_n,
    input  smf_pkg::mem_req_t mreq,
    output smf_pkg::handle_t  rd_handle,
    output smf_pkg::code_t    rd_code,
    output smf_pkg::slot_t    rd_link,
    output logic              init_done
);
    import smf_pkg::*;

    handle_t hmem [Capacity];
    code_t   cmem [Capacity];
    slot_t   lmem [Capacity];

    logic  init_reg;
    slot_t init_ptr_reg;

    // Sweep link memory once after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            init_reg     <= 1'b0;
            init_ptr_reg <= '0;
        end
        else if (!init_reg)
        begin
            init_ptr_reg <= init_ptr_reg + 1'b1;
            if (init_ptr_reg == slot_t'(Capacity - 1))
                init_reg <= 1'b1;
        end
    end
    assign init_done = init_reg;

    // Entry memory
    always_ff @(posedge clk)
    begin
        if (mreq.ent_we)
        begin
            hmem[mreq.ent_addr] <= mreq.ent_handle;
            cmem[mreq.ent_addr] <= mreq.ent_code;
        end
        if (mreq.rd_en)
        begin
            rd_handle <= hmem[mreq.rd_addr];
            rd_code   <= cmem[mreq.rd_addr];
        end
    end

    // Link memory
    always_ff @(posedge clk)
    begin
        if (!init_reg)
            lmem[init_ptr_reg] <= init_ptr_reg + 1'b1;
        else if (mreq.lnk_we)
            lmem[mreq.lnk_addr] <= mreq.lnk_data;
        if (mreq.rd_en)
            rd_link <= lmem[mreq.rd_addr];
    end
endmodule

FILE: design/smf_ctrl.sv
// Command sequencer: walks the linked slots one per cycle, updates pointers.
// Depends on smf_pkg and the read data of smf_store.
`timescale 1ns / 1ps
module smf_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              init_done,
    input  logic              req_valid,
    output logic              req_ready,
    input  smf_pkg::req_t     req,
    output logic              rsp_valid,
    input  logic              rsp_ready,
    output smf_pkg::rsp_t     rsp,
    output smf_pkg::mem_req_t mreq,
    input  smf_pkg::handle_t  rd_handle,
    input  smf_pkg::code_t    rd_code,
    input  smf_pkg::slot_t    rd_link
);
    import smf_pkg::*;

    typedef enum logic [2:0] {S_IDLE, S_FREE, S_WALK, S_UNLINK, S_DONE} state_t;

    state_t   state_reg;
    req_t     req_reg;
    slot_t    head_reg, tail_reg, free_reg;
    count_t   count_reg;
    slot_t    cur_reg, prev_reg;
    count_t   idx_reg;
    pos_t     n_reg;
    rsp_t     rsp_reg;
    logic     rsp_valid_reg;

    logic     hit;
    logic     last;

    assign req_ready = init_done && (state_reg == S_IDLE) && !rsp_valid_reg;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    assign last = (idx_reg + 1'b1) == count_reg;
    always_comb
    begin
        case (req_reg.cmd)
            CMD_REMOVE:  hit = rd_handle == req_reg.handle;
            CMD_FIND_AT: hit = 1'b1;
            default:     hit = rd_code == req_reg.code;
        endcase
    end

    // Memory requests from the current state
    always_comb
    begin
        mreq = '0;
        mreq.ent_handle = req.handle;
        mreq.ent_code   = req.code;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid && req_ready)
                begin
                    mreq.rd_en = 1'b1;
                    unique case (req.cmd)
                        CMD_APPEND: mreq.rd_addr = free_reg;
                        default:    mreq.rd_addr = head_reg;
                    endcase
                    // Append: write the entry now, links once free next is known
                    if (req.cmd == CMD_APPEND && req.handle != '0
                        && count_reg != count_t'(Capacity))
                    begin
                        mreq.ent_we   = 1'b1;
                        mreq.ent_addr = free_reg;
                    end
                end
            end
            S_FREE:
            begin
                // Link old tail to the new slot; new slot link is never read at tail
                mreq.lnk_we   = count_reg != '0;
                mreq.lnk_addr = tail_reg;
                mreq.lnk_data = cur_reg;
            end
            S_WALK:
            begin
                mreq.rd_en   = 1'b1;
                mreq.rd_addr = rd_link;
            end
            S_UNLINK:
            begin
                // Release the removed slot onto the free chain
                mreq.lnk_we   = 1'b1;
                mreq.lnk_addr = cur_reg;
                mreq.lnk_data = free_reg;
            end
            default: ;
        endcase
        // Bypass the predecessor link around the removed slot
        if (state_reg == S_WALK && req_reg.cmd == CMD_REMOVE && hit && idx_reg != '0)
        begin
            mreq.lnk_we   = 1'b1;
            mreq.lnk_addr = prev_reg;
            mreq.lnk_data = rd_link;
        end
    end

    // Sequencer with pointers and registered result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_reg      <= '0;
            tail_reg      <= '0;
            free_reg      <= '0;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
            req_reg       <= '0;
            cur_reg       <= '0;
            prev_reg      <= '0;
            idx_reg       <= '0;
            n_reg         <= '0;
            rsp_reg       <= '0;
        end
        else
        begin
            if (rsp_valid_reg && rsp_ready)
                rsp_valid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (req_valid && req_ready)
                    begin
                        req_reg <= req;
                        cur_reg <= (req.cmd == CMD_APPEND) ? free_reg : head_reg;
                        prev_reg <= head_reg;
                        idx_reg <= '0;
                        n_reg   <= req.position;
                        rsp_reg.status     <= ST_MISSING;
                        rsp_reg.handle_out <= '0;
                        rsp_reg.code_out   <= '0;
                        rsp_reg.count_out  <= count_reg;
                        state_reg <= S_DONE;
                        case (req.cmd)
                            CMD_APPEND:
                            begin
                                if (req.handle == '0)
                                    rsp_reg.status <= ST_NULL;
                                else if (count_reg == count_t'(Capacity))
                                    rsp_reg.status <= ST_FULL;
                                else
                                    state_reg <= S_FREE;
                            end
                            CMD_REMOVE:
                            begin
                                if (req.handle == '0)
                                    rsp_reg.status <= ST_NULL;
                                else if (count_reg != '0)
                                    state_reg <= S_WALK;
                            end
                            CMD_FIND_AT, CMD_FIND_CODE, CMD_IS_HEAD, CMD_POP:
                            begin
                                if (req.cmd == CMD_IS_HEAD && req.handle == '0)
                                    rsp_reg.status <= (count_reg == '0) ? ST_OK : ST_MISSING;
                                else if (count_reg != '0 &&
                                         (req.cmd == CMD_POP || req.cmd == CMD_IS_HEAD
                                          || {3'b0, req.position} < 13'(count_reg)))
                                    state_reg <= S_WALK;
                            end
                            default: ;
                        endcase
                    end
                end
                S_FREE:
                begin
                    free_reg <= rd_link;
                    if (count_reg == '0)
                        head_reg <= cur_reg;
                    tail_reg  <= cur_reg;
                    count_reg <= count_reg + 1'b1;
                    rsp_reg.status    <= ST_OK;
                    rsp_reg.count_out <= count_reg + 1'b1;
                    state_reg <= S_DONE;
                end
                S_WALK:
                begin
                    state_reg <= S_DONE;
                    if (req_reg.cmd == CMD_IS_HEAD)
                        rsp_reg.status <= (rd_handle == req_reg.handle) ? ST_OK : ST_MISSING;
                    else if (req_reg.cmd == CMD_POP || (req_reg.cmd == CMD_REMOVE && hit))
                    begin
                        rsp_reg.status     <= ST_OK;
                        rsp_reg.handle_out <= rd_handle;
                        rsp_reg.code_out   <= rd_code;
                        rsp_reg.count_out  <= count_reg - 1'b1;
                        count_reg <= count_reg - 1'b1;
                        if (idx_reg == '0)
                            head_reg <= rd_link;
                        if (last)
                            tail_reg <= prev_reg;
                        if (req_reg.cmd == CMD_POP && count_reg == count_t'(1))
                        begin
                            head_reg <= '0;
                            tail_reg <= '0;
                        end
                        state_reg <= S_UNLINK;
                    end
                    else if (hit && n_reg == '0)
                    begin
                        rsp_reg.status     <= ST_OK;
                        rsp_reg.handle_out <= rd_handle;
                        rsp_reg.code_out   <= rd_code;
                    end
                    else
                    begin
                        if (hit)
                            n_reg <= n_reg - 1'b1;
                        if (!last)
                        begin
                            prev_reg <= cur_reg;
                            cur_reg  <= rd_link;
                            idx_reg  <= idx_reg + 1'b1;
                            state_reg <= S_WALK;
                        end
                    end
                end
                S_UNLINK:
                begin
                    free_reg  <= cur_reg;
                    state_reg <= S_DONE;
                end
                S_DONE:
                begin
                    rsp_valid_reg <= 1'b1;
                    state_reg     <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule

FILE: design/searchable_message_fifo_unit.sv
// Channel   Dir  Fields
// req       in   cmd, handle, code, position
// rsp       out  status, handle_out, code_out, count_out
//
// From the accepting edge to rsp.valid an item answered at once (null handle, full,
// empty, out of range, undefined command) passes through S_DONE; append passes
// S_FREE, is_head S_WALK, pop S_WALK and S_UNLINK, find walks S_WALK, and remove
// walks then S_UNLINK, all then S_DONE; the walk reads one linked slot per cycle.
// After reset the link memory is chained into a free list before req.ready rises.
// One item is in work at a time; the result register holds until taken, and the
// next item is accepted no earlier than the edge after the result is taken.
// Depends on smf_pkg, smf_if, smf_store, smf_ctrl.
`timescale 1ns / 1ps
module searchable_message_fifo_unit (
    input  logic      clk,
    input  logic      rst_n,
    smf_req_if.sink   req,
    smf_rsp_if.source rsp
);
    import smf_pkg::*;

    mem_req_t mreq;
    handle_t  rd_handle;
    code_t    rd_code;
    slot_t    rd_link;
    logic     init_done;
    req_t     req_bus;
    rsp_t     rsp_bus;

    assign req_bus = '{cmd: req.cmd, handle: req.handle, code: req.code,
                       position: req.position};
    assign rsp.status     = rsp_bus.status;
    assign rsp.handle_out = rsp_bus.handle_out;
    assign rsp.code_out   = rsp_bus.code_out;
    assign rsp.count_out  = rsp_bus.count_out;

    smf_store u_store (
        .clk(clk), .rst_n(rst_n), .mreq(mreq), .rd_handle(rd_handle),
        .rd_code(rd_code), .rd_link(rd_link), .init_done(init_done)
    );

    smf_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .init_done(init_done),
        .req_valid(req.valid), .req_ready(req.ready), .req(req_bus),
        .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp(rsp_bus),
        .mreq(mreq), .rd_handle(rd_handle), .rd_code(rd_code), .rd_link(rd_link)
    );
endmodule
